// ===== hdl/rvd_pkg.sv =====
// Shared types and codes for the RV32 subset instruction decoder.
`default_nettype none

package rvd_pkg;

  localparam logic [6:0] OPC_R     = 7'b0110011;
  localparam logic [6:0] OPC_LUI   = 7'b0110111;
  localparam logic [6:0] OPC_IARI  = 7'b0010011;
  localparam logic [6:0] OPC_LOAD  = 7'b0000011;
  localparam logic [6:0] OPC_STORE = 7'b0100011;
  localparam logic [6:0] OPC_BNE   = 7'b1100011;
  localparam logic [6:0] OPC_JALR  = 7'b1100111;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_OPC   = 2'd1;
  localparam logic [1:0] ST_BAD_ALU   = 2'd2;
  localparam logic [1:0] ST_BAD_WIDTH = 2'd3;

  localparam logic [1:0] PC_INC  = 2'd0;
  localparam logic [1:0] PC_BNE  = 2'd1;
  localparam logic [1:0] PC_JREG = 2'd2;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [1:0] WB_ALU = 2'd0;
  localparam logic [1:0] WB_MEM = 2'd1;
  localparam logic [1:0] WB_PC4 = 2'd2;

  localparam logic [2:0] ALU_ADD  = 3'd0;
  localparam logic [2:0] ALU_SUB  = 3'd1;
  localparam logic [2:0] ALU_OR   = 3'd2;
  localparam logic [2:0] ALU_AND  = 3'd3;
  localparam logic [2:0] ALU_SLTU = 3'd4;
  localparam logic [2:0] ALU_SRA  = 3'd5;
  localparam logic [2:0] ALU_PASS = 3'd6;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_H    = 3'd1;
  localparam logic [2:0] F3_W    = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_BU   = 3'd4;
  localparam logic [2:0] F3_SRA  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] BYTES_1 = 3'd1;
  localparam logic [2:0] BYTES_2 = 3'd2;
  localparam logic [2:0] BYTES_4 = 3'd4;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  pc_mode;
    logic [1:0]  mem_access;
    logic [1:0]  writeback_source;
    logic        alu_uses_imm;
    logic        reg_write;
    logic [2:0]  alu_function;
    logic [31:0] immediate;
    logic [4:0]  src_reg_a;
    logic [4:0]  src_reg_b;
    logic [4:0]  dest_reg;
    logic [2:0]  access_bytes;
  } decode_t;

endpackage

`default_nettype wire

// ===== hdl/rvd_decode.sv =====
// Combinational decode of one instruction word into control fields.
`default_nettype none

module rvd_decode
  import rvd_pkg::*;
(
  input  wire logic [31:0] word,
  output decode_t          dec
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic       is_r;
  logic       use_f3_alu;
  decode_t    raw;

  assign opc = word[6:0];
  assign f3  = word[14:12];

  always_comb begin
    raw            = '0;
    raw.status     = ST_OK;
    raw.src_reg_a  = word[19:15];
    raw.src_reg_b  = word[24:20];
    raw.dest_reg   = word[11:7];
    is_r           = 1'b0;
    use_f3_alu     = 1'b0;
    unique case (opc)
      OPC_R: begin
        is_r          = 1'b1;
        use_f3_alu    = 1'b1;
        raw.reg_write = 1'b1;
      end
      OPC_LUI: begin
        raw.alu_function = ALU_PASS;
        raw.alu_uses_imm = 1'b1;
        raw.reg_write    = 1'b1;
        raw.immediate    = {word[31:12], 12'd0};
      end
      OPC_IARI: begin
        use_f3_alu       = 1'b1;
        raw.alu_uses_imm = 1'b1;
        raw.reg_write    = 1'b1;
        raw.immediate    = {{20{word[31]}}, word[31:20]};
      end
      OPC_LOAD: begin
        raw.mem_access       = MEM_LOAD;
        raw.writeback_source = WB_MEM;
        raw.alu_uses_imm     = 1'b1;
        raw.reg_write        = 1'b1;
        raw.immediate        = {{20{word[31]}}, word[31:20]};
      end
      OPC_STORE: begin
        raw.mem_access   = MEM_STORE;
        raw.alu_uses_imm = 1'b1;
        raw.immediate    = {{20{word[31]}}, word[31:25], word[11:7]};
      end
      OPC_BNE: begin
        raw.pc_mode      = PC_BNE;
        raw.alu_function = ALU_SUB;
        raw.immediate    = {{19{word[31]}}, word[31], word[7], word[30:25],
                            word[11:8], 1'b0};
      end
      OPC_JALR: begin
        raw.pc_mode          = PC_JREG;
        raw.writeback_source = WB_PC4;
        raw.alu_uses_imm     = 1'b1;
        raw.reg_write        = 1'b1;
        raw.immediate        = {{20{word[31]}}, word[31:20]};
      end
      default: begin
        raw.status = ST_BAD_OPC;
      end
    endcase

    if (use_f3_alu) begin
      unique case (f3)
        F3_ADD:  raw.alu_function = is_r ? ALU_SUB : ALU_ADD;
        F3_SLTU: raw.alu_function = ALU_SLTU;
        F3_SRA:  raw.alu_function = ALU_SRA;
        F3_OR:   raw.alu_function = ALU_OR;
        F3_AND:  raw.alu_function = ALU_AND;
        default: raw.status       = ST_BAD_ALU;
      endcase
    end

    if (raw.mem_access != MEM_NONE) begin
      unique case (f3)
        F3_BU:   raw.access_bytes = BYTES_1;
        F3_H:    raw.access_bytes = BYTES_2;
        F3_W:    raw.access_bytes = BYTES_4;
        default: raw.status       = ST_BAD_WIDTH;
      endcase
    end

    // drop every field but the status on a fault
    if (raw.status != ST_OK) begin
      dec        = '0;
      dec.status = raw.status;
    end else begin
      dec = raw;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rv32_subset_instruction_decoder_core.sv =====
// Top level of the RV32 subset instruction decoder: input and result registers.
//
// Usage:
//   Raise start with an instruction word; the word transfers at the rising edge
//   where start is high and busy is low. busy is always low, so a new word can
//   transfer in every cycle and the block sustains one instruction per cycle.
//   The word lands in an input register, passes one stage of decode logic and
//   lands in the result register at the edge after the transfer edge:
//   done is high for exactly one cycle with all result fields valid, and
//   they transfer at the edge that ends that cycle.
//   The receiver cannot stall; each result is shown once, in transfer order.
//   An unknown opcode, or a funct3 that an ALU, load or store instruction does
//   not support, gives a non-zero status with all other fields zero. The two
//   registers are the input and result registers; decode is combinational.
//   Synchronous reset (rst high) clears the pipeline valid flags; words in
//   flight are dropped and done stays low until a new word transfers.
//
`default_nettype none

module rv32_subset_instruction_decoder_core
  import rvd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [31:0]        instruction,
  output logic                    done,
  output logic [1:0]              status,
  output logic [1:0]              pc_mode,
  output logic [1:0]              mem_access,
  output logic [1:0]              writeback_source,
  output logic                    alu_uses_imm,
  output logic                    reg_write,
  output logic [2:0]              alu_function,
  output logic signed [31:0]      immediate,
  output logic [4:0]              src_reg_a,
  output logic [4:0]              src_reg_b,
  output logic [4:0]              dest_reg,
  output logic [2:0]              access_bytes
);

  logic        in_valid;
  logic [31:0] in_word;
  decode_t     dec;
  decode_t     result;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_word <= instruction;
    end
    if (in_valid) begin
      result <= dec;
    end
  end

  rvd_decode u_decode (
    .word (in_word),
    .dec  (dec)
  );

  assign status           = result.status;
  assign pc_mode          = result.pc_mode;
  assign mem_access       = result.mem_access;
  assign writeback_source = result.writeback_source;
  assign alu_uses_imm     = result.alu_uses_imm;
  assign reg_write        = result.reg_write;
  assign alu_function     = result.alu_function;
  assign immediate        = $signed(result.immediate);
  assign src_reg_a        = result.src_reg_a;
  assign src_reg_b        = result.src_reg_b;
  assign dest_reg         = result.dest_reg;
  assign access_bytes     = result.access_bytes;

endmodule

`default_nettype wire
